@@ rtl/core/hotkey_match_table_core_assert.svh @@
// Assertion macros for the hotkey match table core
`ifndef HOTKEY_MATCH_TABLE_CORE_ASSERT_SVH
`define HOTKEY_MATCH_TABLE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define HMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hotkey_match_table_core: assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define HMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hotkey_match_table_core: assertion failed");

`endif

@@ rtl/core/hmt_pkg.sv @@
`default_nettype none

package hmt_pkg;

  localparam int unsigned COMBO_W = 12;
  localparam int unsigned TOTAL_W = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] key_code;
    logic       shift_flag;
    logic       control_flag;
    logic       alt_flag;
    logic       meta_flag;
  } item_t;

  typedef struct packed {
    logic               status;
    logic               grabbed;
    logic [TOTAL_W-1:0] entry_total;
  } result_t;

  function automatic logic [COMBO_W-1:0] pack_combo(input item_t item);
    pack_combo = {item.meta_flag, item.alt_flag, item.control_flag, item.shift_flag,
                  item.key_code};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hmt_store.sv @@
`default_nettype none

module hmt_store #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ADDR_W      = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [ADDR_W-1:0]           waddr_i,
  input  wire logic [hmt_pkg::COMBO_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]           raddr_i,
  output logic      [hmt_pkg::COMBO_W-1:0] rdata_o
);

  logic [hmt_pkg::COMBO_W-1:0] mem [TABLE_DEPTH];
  logic [hmt_pkg::COMBO_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/hmt_seq.sv @@
`default_nettype none

module hmt_seq #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ADDR_W      = 6,
  parameter int unsigned CNT_W       = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire hmt_pkg::item_t              in_item_i,
  input  wire logic                        out_free_i,
  output logic                             push_o,
  output hmt_pkg::result_t                 result_o,
  output logic                             mem_we_o,
  output logic      [ADDR_W-1:0]           mem_waddr_o,
  output logic      [hmt_pkg::COMBO_W-1:0] mem_wdata_o,
  output logic      [ADDR_W-1:0]           mem_raddr_o,
  input  wire logic [hmt_pkg::COMBO_W-1:0] mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [1:0]                  op_q, op_d;
  logic [hmt_pkg::COMBO_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]            idx_q, idx_d;
  logic [CNT_W-1:0]            kept_q, kept_d;
  logic                        found_q, found_d;
  logic                        status_q, status_d;
  logic                        grabbed_q, grabbed_d;
  logic                        eq;

  assign eq = (mem_rdata_i == key_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    key_d       = key_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    found_d     = found_q;
    status_d    = status_q;
    grabbed_d   = grabbed_q;
    push_o      = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = kept_q[ADDR_W-1:0];
    mem_wdata_o = mem_rdata_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_item_i.mode;
          key_d     = hmt_pkg::pack_combo(in_item_i);
          idx_d     = '0;
          kept_d    = '0;
          found_d   = 1'b0;
          status_d  = 1'b0;
          grabbed_d = 1'b0;
          if (in_item_i.mode == hmt_pkg::MODE_INSERT ||
              in_item_i.mode == hmt_pkg::MODE_REMOVE ||
              in_item_i.mode == hmt_pkg::MODE_QUERY) begin
            state_d = S_RD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_RD: begin
        if (idx_q == cnt_q) begin
          case (op_q)
            hmt_pkg::MODE_INSERT: begin
              if (!found_q) begin
                if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
                  status_d = 1'b1;
                end else begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = cnt_q[ADDR_W-1:0];
                  mem_wdata_o = key_q;
                  cnt_d       = cnt_q + CNT_W'(1);
                end
              end
            end
            hmt_pkg::MODE_REMOVE: begin
              cnt_d = kept_q;
            end
            hmt_pkg::MODE_QUERY: begin
              grabbed_d = found_q;
            end
            default: begin
            end
          endcase
          state_d = S_FIN;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        found_d = found_q | eq;
        if (op_q == hmt_pkg::MODE_REMOVE && !eq) begin
          mem_we_o = 1'b1;
          kept_d   = kept_q + CNT_W'(1);
        end
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_RD;
      end
      S_FIN: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_raddr_o          = idx_q[ADDR_W-1:0];
  assign in_ready_o           = (state_q == S_IDLE);
  assign result_o.status      = status_q;
  assign result_o.grabbed     = grabbed_q;
  assign result_o.entry_total = hmt_pkg::TOTAL_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    idx_q     <= idx_d;
    kept_q    <= kept_d;
    found_q   <= found_d;
    status_q  <= status_d;
    grabbed_q <= grabbed_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/hotkey_match_table_core.sv @@
// Flow: an item is taken only in S_IDLE, so one item is handled at a time. The walk visits
// each held entry in turn, a read state (S_RD) then a compare state (S_CMP), through the single
// table read port and comparator; S_FIN then waits for the output register to be free.
// Unused mode: skips the table walk and goes straight to S_FIN. Result sits in an output register.
// Reset: entry count and control cleared; table contents are not cleared.
`default_nettype none

module hotkey_match_table_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire hmt_pkg::item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output hmt_pkg::result_t      out_item_o
);

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic                        out_valid_q, out_valid_d;
  hmt_pkg::result_t            out_item_q, out_item_d;
  logic                        out_free;
  logic                        push;
  hmt_pkg::result_t            result;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [hmt_pkg::COMBO_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [hmt_pkg::COMBO_W-1:0] mem_rdata;

  assign out_free = !out_valid_q || out_ready_i;

  hmt_seq #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ADDR_W     (ADDR_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_free_i (out_free),
    .push_o     (push),
    .result_o   (result),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  hmt_store #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_item_d  = result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

@@ rtl/core/hmt_checker.sv @@
`default_nettype none
`include "hotkey_match_table_core_assert.svh"

module hmt_checker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire hmt_pkg::result_t out_item_o
);

  `HMT_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `HMT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  `HMT_ASSERT_IMP(a_full_total, out_valid_o && out_item_o.status, out_item_o.entry_total == hmt_pkg::TOTAL_W'(TABLE_DEPTH))
  `HMT_ASSERT_IMP(a_status_grab_excl, out_valid_o, !(out_item_o.status && out_item_o.grabbed))

endmodule

bind hotkey_match_table_core hmt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_hmt_checker (.*);

`default_nettype wire
